// ----- sv/tdcc_pkg.sv -----
// Shared types, constants and the month-length function of the calendar clock.
`default_nettype none
package tdcc_pkg;

    localparam int CfgIndexW = 8;
    localparam int CfgDataW  = 8;
    localparam int SecW      = 6;
    localparam int MinW      = 6;
    localparam int HourW     = 5;
    localparam int DayW      = 5;
    localparam int MonW      = 4;
    localparam int YearW     = 14;

    // Configuration register indexes
    localparam logic [CfgIndexW-1:0] CfgTicksPerSub = CfgIndexW'(0);
    localparam logic [CfgIndexW-1:0] CfgSubsPerSec  = CfgIndexW'(1);

    localparam logic [CfgDataW-1:0] TicksPerSubRst = CfgDataW'(38);
    localparam logic [CfgDataW-1:0] SubsPerSecRst  = CfgDataW'(101);

    localparam logic [SecW-1:0]  SecLast  = SecW'(59);
    localparam logic [MinW-1:0]  MinLast  = MinW'(59);
    localparam logic [HourW-1:0] HourLast = HourW'(23);
    localparam logic [YearW-1:0] YearLast = YearW'(9999);
    localparam logic [DayW-1:0]  DayFirst = DayW'(1);

    localparam logic [MonW-1:0] MonJan = MonW'(1);
    localparam logic [MonW-1:0] MonFeb = MonW'(2);
    localparam logic [MonW-1:0] MonApr = MonW'(4);
    localparam logic [MonW-1:0] MonJun = MonW'(6);
    localparam logic [MonW-1:0] MonSep = MonW'(9);
    localparam logic [MonW-1:0] MonNov = MonW'(11);
    localparam logic [MonW-1:0] MonDec = MonW'(12);

    localparam logic [DayW-1:0] DaysLong  = DayW'(31);
    localparam logic [DayW-1:0] DaysShort = DayW'(30);
    localparam logic [DayW-1:0] DaysFeb   = DayW'(28);
    localparam logic [DayW-1:0] DaysLeap  = DayW'(29);

    typedef struct packed {
        logic [SecW-1:0]  seconds;
        logic [MinW-1:0]  minutes;
        logic [HourW-1:0] hours;
        logic [DayW-1:0]  day;
        logic [MonW-1:0]  month;
        logic [YearW-1:0] year;
    } t_cal;

    localparam t_cal CalRst = '{
        seconds: SecW'(55),
        minutes: MinW'(59),
        hours:   HourW'(23),
        day:     DayW'(31),
        month:   MonW'(12),
        year:    YearW'(2015)
    };

    typedef struct packed {
        logic sub_p;
        logic sec_p;
    } t_pre;

    typedef struct packed {
        logic sub_p;
        logic sec_p;
        logic day_p;
    } t_pulse;

    // Every year divisible by four is a leap year
    function automatic logic [DayW-1:0] days_in_month(input logic [MonW-1:0] m,
                                                      input logic [YearW-1:0] y);
        logic [DayW-1:0] d;
        d = DaysLong;
        case (m) inside
            MonFeb:                         d = (y[1:0] == 2'b00) ? DaysLeap : DaysFeb;
            MonApr, MonJun, MonSep, MonNov: d = DaysShort;
            default:                        d = DaysLong;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

// ----- sv/tdcc_ifs.sv -----
// Handshake channel interfaces: tick input, time result and configuration write.
`default_nettype none
interface tdcc_tick_if;
    logic valid;
    logic ready;
    logic tick;
    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface

interface tdcc_time_if;
    logic                       valid;
    logic                       ready;
    logic [tdcc_pkg::SecW-1:0]  seconds;
    logic [tdcc_pkg::MinW-1:0]  minutes;
    logic [tdcc_pkg::HourW-1:0] hours;
    logic [tdcc_pkg::DayW-1:0]  day_of_month;
    logic [tdcc_pkg::MonW-1:0]  month_of_year;
    logic [tdcc_pkg::YearW-1:0] year_count;
    logic                       subsecond_pulse;
    logic                       second_pulse;
    logic                       day_pulse;
    modport source (output valid, output seconds, output minutes, output hours,
                    output day_of_month, output month_of_year, output year_count,
                    output subsecond_pulse, output second_pulse, output day_pulse,
                    input ready);
    modport sink   (input valid, input seconds, input minutes, input hours,
                    input day_of_month, input month_of_year, input year_count,
                    input subsecond_pulse, input second_pulse, input day_pulse,
                    output ready);
endinterface

interface tdcc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tdcc_pkg::CfgIndexW-1:0] index;
    logic [tdcc_pkg::CfgDataW-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/tick_driven_calendar_clock.sv -----
// Top level of the tick-driven calendar clock with its result register.
// Each accepted item is one timer tick; the block answers it with one result item holding the
// time and date after that tick plus the sub-second, second and day pulses it caused. Items
// are taken one per clock cycle when not stalled: the counter and calendar update is settled
// in the cycle of acceptance and the result lands in a single output register, valid in the
// next cycle; input ready follows output ready while that register is full. Configuration
// writes to index 0 (ticks per sub-second) and index 1 (sub-seconds per second) are always
// taken; other indexes are dropped. After reset the clock reads 23:59:55 on 31 December 2015.
`default_nettype none
module tick_driven_calendar_clock (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tdcc_tick_if.sink   i_tick_ch,
    tdcc_cfg_if.sink    i_cfg,
    tdcc_time_if.source o_time
);
    logic [tdcc_pkg::CfgDataW-1:0] r_ticks_per_sub;
    logic [tdcc_pkg::CfgDataW-1:0] r_subs_per_sec;
    logic                          r_out_valid;
    tdcc_pkg::t_cal                r_res_cal;
    tdcc_pkg::t_pulse              r_res_pulse;

    logic           in_acc;
    logic           adv;
    tdcc_pkg::t_pre pre;
    tdcc_pkg::t_cal cal;
    logic           day_p;

    assign i_tick_ch.ready = !r_out_valid || o_time.ready;
    assign in_acc          = i_tick_ch.valid && i_tick_ch.ready;
    assign adv             = in_acc && i_tick_ch.tick;
    assign i_cfg.ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_sub <= tdcc_pkg::TicksPerSubRst;
            r_subs_per_sec  <= tdcc_pkg::SubsPerSecRst;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                tdcc_pkg::CfgTicksPerSub: r_ticks_per_sub <= i_cfg.data;
                tdcc_pkg::CfgSubsPerSec:  r_subs_per_sec  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    tdcc_prescale u_prescale (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (adv),
        .i_ticks_per_sub (r_ticks_per_sub),
        .i_subs_per_sec  (r_subs_per_sec),
        .o_pre           (pre)
    );

    tdcc_calendar u_calendar (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (pre.sec_p),
        .o_cal   (cal),
        .o_day_p (day_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_time.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload: capture the state after this item
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res_cal   <= cal;
            r_res_pulse <= '{sub_p: pre.sub_p, sec_p: pre.sec_p, day_p: day_p};
        end
    end

    assign o_time.valid           = r_out_valid;
    assign o_time.seconds         = r_res_cal.seconds;
    assign o_time.minutes         = r_res_cal.minutes;
    assign o_time.hours           = r_res_cal.hours;
    assign o_time.day_of_month    = r_res_cal.day;
    assign o_time.month_of_year   = r_res_cal.month;
    assign o_time.year_count      = r_res_cal.year;
    assign o_time.subsecond_pulse = r_res_pulse.sub_p;
    assign o_time.second_pulse    = r_res_pulse.sec_p;
    assign o_time.day_pulse       = r_res_pulse.day_p;

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_time.valid)
        else $error("no result after an accepted item");

    a_pulse_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_time.valid |-> ((!o_time.day_pulse || o_time.second_pulse)
                          && (!o_time.second_pulse || o_time.subsecond_pulse)))
        else $error("pulse without the pulse below it");

    a_second_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_time.valid && o_time.day_pulse) |-> (o_time.seconds == '0
            && o_time.minutes == '0 && o_time.hours == '0))
        else $error("day advanced but time of day is not midnight");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_time.valid && !o_time.ready) |-> !i_tick_ch.ready)
        else $error("item accepted while result is stalled");
`endif
endmodule
`default_nettype wire

// ----- sv/tdcc_prescale.sv -----
// Tick prescaler and sub-second counter with their wrap pulses.
`default_nettype none
module tdcc_prescale (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_adv,
    input  wire logic [tdcc_pkg::CfgDataW-1:0] i_ticks_per_sub,
    input  wire logic [tdcc_pkg::CfgDataW-1:0] i_subs_per_sec,
    output tdcc_pkg::t_pre                     o_pre
);
    logic [tdcc_pkg::CfgDataW-1:0] r_tick_prescale, n_tick_prescale;
    logic [tdcc_pkg::CfgDataW-1:0] r_subsecond_count, n_subsecond_count;
    logic                          sub_wrap, sec_wrap;

    // Wrap when count + 1 reaches the limit; a zero limit wraps every step
    assign sub_wrap = ({1'b0, r_tick_prescale} + 9'd1) >= {1'b0, i_ticks_per_sub};
    assign sec_wrap = ({1'b0, r_subsecond_count} + 9'd1) >= {1'b0, i_subs_per_sec};

    always_comb begin
        n_tick_prescale   = r_tick_prescale;
        n_subsecond_count = r_subsecond_count;
        o_pre             = '0;
        if (i_adv) begin
            if (sub_wrap) begin
                n_tick_prescale = '0;
                o_pre.sub_p     = 1'b1;
                if (sec_wrap) begin
                    n_subsecond_count = '0;
                    o_pre.sec_p       = 1'b1;
                end else begin
                    n_subsecond_count = r_subsecond_count + 1'b1;
                end
            end else begin
                n_tick_prescale = r_tick_prescale + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_prescale   <= '0;
            r_subsecond_count <= '0;
        end else begin
            r_tick_prescale   <= n_tick_prescale;
            r_subsecond_count <= n_subsecond_count;
        end
    end
endmodule
`default_nettype wire

// ----- sv/tdcc_calendar.sv -----
// Seconds, minutes, hours, day, month and year cascade.
`default_nettype none
module tdcc_calendar (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_step,
    output tdcc_pkg::t_cal o_cal,
    output logic           o_day_p
);
    tdcc_pkg::t_cal r_cal, n_cal;

    always_comb begin
        n_cal   = r_cal;
        o_day_p = 1'b0;
        if (i_step) begin
            if (r_cal.seconds != tdcc_pkg::SecLast) begin
                n_cal.seconds = r_cal.seconds + 1'b1;
            end else begin
                n_cal.seconds = '0;
                if (r_cal.minutes != tdcc_pkg::MinLast) begin
                    n_cal.minutes = r_cal.minutes + 1'b1;
                end else begin
                    n_cal.minutes = '0;
                    if (r_cal.hours != tdcc_pkg::HourLast) begin
                        n_cal.hours = r_cal.hours + 1'b1;
                    end else begin
                        n_cal.hours = '0;
                        o_day_p     = 1'b1;
                        if (r_cal.day >= tdcc_pkg::days_in_month(r_cal.month, r_cal.year)) begin
                            n_cal.day = tdcc_pkg::DayFirst;
                            if (r_cal.month == tdcc_pkg::MonDec) begin
                                n_cal.month = tdcc_pkg::MonJan;
                                n_cal.year  = (r_cal.year == tdcc_pkg::YearLast) ? '0
                                                                                  : r_cal.year + 1'b1;
                            end else begin
                                n_cal.month = r_cal.month + 1'b1;
                            end
                        end else begin
                            n_cal.day = r_cal.day + 1'b1;
                        end
                    end
                end
            end
        end
    end

    assign o_cal = n_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= tdcc_pkg::CalRst;
        end else begin
            r_cal <= n_cal;
        end
    end
endmodule
`default_nettype wire

// ----- verif/tdcc_time_checker.sv -----
`timescale 1ns / 100ps
// Time checker: tracks the calendar clock on every tick item and compares each result item.
module tdcc_time_checker
    import tdcc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    tdcc_tick_if i_tick_ch,
    tdcc_cfg_if  i_cfg,
    tdcc_time_if i_time,
    output int   o_pending,
    output int   o_fail_count
);

    typedef struct packed {
        t_cal   cal;
        t_pulse pulse;
    } t_time_item;

    t_time_item          expected_times[$];
    t_time_item          seen;
    t_time_item          want;
    t_cal                now_cal;
    logic [CfgDataW-1:0] ticks_per_sub;
    logic [CfgDataW-1:0] subs_per_sec;
    logic [CfgDataW-1:0] tick_prescale;
    logic [CfgDataW-1:0] subsec_count;
    int                  pending_items = 0;
    int                  fail_total = 0;

    assign o_pending    = pending_items;
    assign o_fail_count = fail_total;

    function automatic logic [DayW-1:0] month_length(input logic [MonW-1:0]  m,
                                                     input logic [YearW-1:0] y);
        if (m == MonFeb)
            return (y % 4 == 0) ? DaysLeap : DaysFeb;
        if (m == MonApr || m == MonJun || m == MonSep || m == MonNov)
            return DaysShort;
        return DaysLong;
    endfunction

    // Advance one second through the cascade; return 1 when the date rolled over.
    function automatic logic step_second();
        if (now_cal.seconds < SecLast) begin
            now_cal.seconds++;
            return 1'b0;
        end
        now_cal.seconds = '0;
        if (now_cal.minutes < MinLast) begin
            now_cal.minutes++;
            return 1'b0;
        end
        now_cal.minutes = '0;
        if (now_cal.hours < HourLast) begin
            now_cal.hours++;
            return 1'b0;
        end
        now_cal.hours = '0;
        if (now_cal.day < month_length(now_cal.month, now_cal.year)) begin
            now_cal.day++;
        end else begin
            now_cal.day = DayFirst;
            if (now_cal.month < MonDec) begin
                now_cal.month++;
            end else begin
                now_cal.month = MonJan;
                now_cal.year  = (now_cal.year < YearLast) ? now_cal.year + 1'b1 : '0;
            end
        end
        return 1'b1;
    endfunction

    function automatic t_time_item time_after_tick(input logic tick);
        t_time_item r;
        r.pulse = '0;
        if (tick) begin
            // A register of zero behaves as one: the wrap test is count + 1 >= register
            if (int'(tick_prescale) + 1 >= int'(ticks_per_sub)) begin
                tick_prescale = '0;
                r.pulse.sub_p = 1'b1;
            end else begin
                tick_prescale++;
            end
            if (r.pulse.sub_p) begin
                if (int'(subsec_count) + 1 >= int'(subs_per_sec)) begin
                    subsec_count  = '0;
                    r.pulse.sec_p = 1'b1;
                end else begin
                    subsec_count++;
                end
            end
            if (r.pulse.sec_p)
                r.pulse.day_p = step_second();
        end
        r.cal = now_cal;
        return r;
    endfunction

    function automatic string fmt_time(input t_time_item v);
        return $sformatf("%0d-%0d-%0d %0d:%0d:%0d sub=%0b sec=%0b day=%0b",
                         v.cal.year, v.cal.month, v.cal.day, v.cal.hours,
                         v.cal.minutes, v.cal.seconds,
                         v.pulse.sub_p, v.pulse.sec_p, v.pulse.day_p);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ticks_per_sub = TicksPerSubRst;
            subs_per_sec  = SubsPerSecRst;
            tick_prescale = '0;
            subsec_count  = '0;
            now_cal       = CalRst;
            expected_times.delete();
        end else begin
            // Compare the result first: it belongs to an older tick than one taken now
            if (i_time.valid && i_time.ready) begin
                seen.cal.seconds = i_time.seconds;
                seen.cal.minutes = i_time.minutes;
                seen.cal.hours   = i_time.hours;
                seen.cal.day     = i_time.day_of_month;
                seen.cal.month   = i_time.month_of_year;
                seen.cal.year    = i_time.year_count;
                seen.pulse.sub_p = i_time.subsecond_pulse;
                seen.pulse.sec_p = i_time.second_pulse;
                seen.pulse.day_p = i_time.day_pulse;
                if (expected_times.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("%0t: unexpected result item: %s", $realtime, fmt_time(seen));
                end else begin
                    want = expected_times.pop_front();
                    if (want !== seen) begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display("%0t: time mismatch: expected %s, got %s",
                                     $realtime, fmt_time(want), fmt_time(seen));
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CfgTicksPerSub: ticks_per_sub = i_cfg.data;
                    CfgSubsPerSec:  subs_per_sec  = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_tick_ch.valid && i_tick_ch.ready)
                expected_times.push_back(time_after_tick(i_tick_ch.tick));
        end
        pending_items = expected_times.size();
    end

endmodule

// ----- verif/tick_driven_calendar_clock_tb.sv -----
`timescale 1ns / 100ps
// Testbench top: drives ticks and register writes into the calendar clock and gives the verdict.
module tick_driven_calendar_clock_tb;
    import tdcc_pkg::*;

    localparam int CycleLimit    = 100000;
    localparam int PhaseCount    = 10;
    localparam int PhaseItems    = 135;
    localparam int SettleCycles  = 3;

    // Indexes that map to no register
    localparam logic [CfgIndexW-1:0] CfgNoReg    = CfgIndexW'(2);
    localparam logic [CfgIndexW-1:0] CfgIndexTop = '1;

    // A negative plan slot means pick a small random setting; zero is written as it is
    localparam int TicksPlan[PhaseCount] = '{1, 2, 255, 1, 0, 3, 38, 1, -1, -1};
    localparam int SubsPlan[PhaseCount]  = '{1, 1, 1, 255, 2, 0, 101, 60, -1, -1};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycle_count = 0;
    int   gap_pct = 0;
    int   stall_pct = 0;
    int   pending;
    int   fail_count;

    tdcc_tick_if tick_ch ();
    tdcc_cfg_if  cfg_ch ();
    tdcc_time_if time_ch ();

    tick_driven_calendar_clock dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick_ch (tick_ch),
        .i_cfg     (cfg_ch),
        .o_time    (time_ch)
    );

    tdcc_time_checker time_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick_ch    (tick_ch),
        .i_cfg        (cfg_ch),
        .i_time       (time_ch),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        time_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Call at a falling edge; returns at the falling edge after the item is taken, valid still high.
    task automatic send_tick(input logic tick);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            tick_ch.valid <= 1'b0;
            tick_ch.tick  <= $urandom_range(1);
            @(negedge i_clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.tick  <= tick;
        do @(posedge i_clk); while (!tick_ch.ready);
        @(negedge i_clk);
    endtask

    // Hold the ticks until every result item is back and the block is idle.
    task automatic drain();
        tick_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIndexW-1:0] index,
                             input logic [CfgDataW-1:0]  data,
                             input bit                   last);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        if (last)
            cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        logic [CfgDataW-1:0] ticks_set;
        logic [CfgDataW-1:0] subs_set;

        tick_ch.valid = 1'b0;
        tick_ch.tick  = 1'b1;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = CfgTicksPerSub;
        cfg_ch.data   = '0;
        time_ch.ready = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: an idle item, then two ticks with no pulse
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        drain();
        // Lower the prescale below its running count: wrap on the next tick
        write_reg(CfgTicksPerSub, CfgDataW'(1), 1'b1);
        send_tick(1'b1);
        drain();
        // Zero acts as one; roll 23:59:55 on New Year's Eve into the next year
        write_reg(CfgSubsPerSec, '0, 1'b1);
        repeat (5) send_tick(1'b1);
        send_tick(1'b0);
        drain();
        write_reg(CfgTicksPerSub, '0, 1'b0);
        write_reg(CfgNoReg, CfgDataW'($urandom), 1'b0);
        write_reg(CfgIndexTop, '1, 1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        drain();
        write_reg(CfgTicksPerSub, '1, 1'b0);
        write_reg(CfgSubsPerSec, '1, 1'b1);
        repeat (3) send_tick(1'b1);
        drain();

        for (int p = 0; p < PhaseCount; p++) begin
            ticks_set = (TicksPlan[p] < 0) ? CfgDataW'($urandom_range(1, 3))
                                           : CfgDataW'(TicksPlan[p]);
            subs_set  = (SubsPlan[p] < 0) ? CfgDataW'($urandom_range(1, 3))
                                          : CfgDataW'(SubsPlan[p]);
            write_reg(CfgTicksPerSub, ticks_set, 1'b0);
            if ($urandom_range(1))
                write_reg(CfgIndexW'($urandom_range(int'(CfgNoReg), int'(CfgIndexTop))),
                          CfgDataW'($urandom), 1'b0);
            write_reg(CfgSubsPerSec, subs_set, 1'b1);
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 45; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 45; end
                default: begin gap_pct = 24; stall_pct = 24; end
            endcase
            for (int n = 0; n < PhaseItems; n++) begin
                if ($urandom_range(199) == 0)
                    drain();
                send_tick($urandom_range(19) != 0);
            end
            drain();
            gap_pct   = 0;
            stall_pct = 0;
        end

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
